// ----- rtl/dqg_pkg.sv -----
// dqg_pkg: shared types, latencies, register indexes and corner table
// for the decal quad generator; used by every rtl file
`timescale 1ns / 1ps
package dqg_pkg;

  localparam int SQRT_LAT   = 32;
  localparam int DIV_LAT    = 15;
  localparam int NORM_LAT   = SQRT_LAT + DIV_LAT + 3;
  localparam int AXIS_LIMIT = 16221;

  localparam logic [1:0] REG_EFFECT_LEVEL = 2'd0;
  localparam logic [1:0] REG_CULL_FAR_SQ  = 2'd1;
  localparam logic [1:0] REG_CULL_NEAR_SQ = 2'd2;
  localparam logic [1:0] REG_HALF_SIZE    = 2'd3;

  localparam logic [1:0] LAST_CORNER_IDX = 2'd3;

  typedef struct packed {
    logic signed [31:0] hit_x;
    logic signed [31:0] hit_y;
    logic signed [31:0] hit_z;
    logic signed [15:0] norm_x;
    logic signed [15:0] norm_y;
    logic signed [15:0] norm_z;
    logic signed [31:0] viewer_x;
    logic signed [31:0] viewer_y;
    logic signed [31:0] viewer_z;
  } item_t;

  typedef struct packed {
    logic signed [31:0] vert_x;
    logic signed [31:0] vert_y;
    logic signed [31:0] vert_z;
    logic               tex_u;
    logic               tex_v;
    logic               last_corner;
  } result_t;

  typedef logic [2:0][23:0] vec3c_t;
  typedef logic [2:0][15:0] unit3_t;
  typedef logic [2:0][31:0] pos3_t;

  function automatic logic corner_cx_neg(input logic [1:0] idx);
    return (idx == 2'd0) || (idx == 2'd1);
  endfunction

  function automatic logic corner_cy_neg(input logic [1:0] idx);
    return (idx == 2'd0) || (idx == 2'd3);
  endfunction

  function automatic logic corner_u(input logic [1:0] idx);
    return (idx == 2'd0) || (idx == 2'd1);
  endfunction

  function automatic logic corner_v(input logic [1:0] idx);
    return (idx == 2'd1) || (idx == 2'd2);
  endfunction

endpackage

// ----- rtl/dqg_sqrt.sv -----
// dqg_sqrt: pipelined integer square root of a 64-bit value, one result
// bit per stage; depends on dqg_pkg
`timescale 1ns / 1ps
module dqg_sqrt import dqg_pkg::*; (
  input  logic        clk,
  input  logic [63:0] radicand,
  output logic [31:0] root
);

  logic [63:0] rem_q [SQRT_LAT];
  logic [63:0] res_q [SQRT_LAT];

  for (genvar k = 0; k < SQRT_LAT; k++) begin : g_stage
    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
    logic [63:0] rem_in;
    logic [63:0] res_in;
    logic [63:0] trial;

    if (k == 0) begin : g_first
      assign rem_in = radicand;
      assign res_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign res_in = res_q[k-1];
    end

    assign trial = res_in + BIT;

    always_ff @(posedge clk) begin
      if (rem_in >= trial) begin
        rem_q[k] <= rem_in - trial;
        res_q[k] <= (res_in >> 1) + BIT;
      end else begin
        rem_q[k] <= rem_in;
        res_q[k] <= res_in >> 1;
      end
    end
  end

  assign root = res_q[SQRT_LAT-1][31:0];

endmodule

// ----- rtl/dqg_div.sv -----
// dqg_div: three-lane pipelined restoring divider, shared divisor,
// one quotient bit per stage; depends on dqg_pkg
`timescale 1ns / 1ps
module dqg_div import dqg_pkg::*; (
  input  logic                         clk,
  input  logic [2:0][47:0]             num,
  input  logic [31:0]                  den,
  output logic [2:0][DIV_LAT-1:0]      quo
);

  logic [2:0][47:0]        rem_q [DIV_LAT];
  logic [2:0][DIV_LAT-1:0] q_q   [DIV_LAT];
  logic [31:0]             den_q [DIV_LAT];

  for (genvar k = 0; k < DIV_LAT; k++) begin : g_stage
    localparam int SH = DIV_LAT - 1 - k;
    logic [2:0][47:0]        rem_in;
    logic [2:0][DIV_LAT-1:0] q_in;
    logic [31:0]             den_in;
    logic [47:0]             trial;

    if (k == 0) begin : g_first
      assign rem_in = num;
      assign q_in   = '0;
      assign den_in = den;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign q_in   = q_q[k-1];
      assign den_in = den_q[k-1];
    end

    assign trial = {16'd0, den_in} << SH;

    always_ff @(posedge clk) begin
      den_q[k] <= den_in;
      for (int l = 0; l < 3; l++) begin
        if (rem_in[l] >= trial) begin
          rem_q[k][l] <= rem_in[l] - trial;
          q_q[k][l]   <= {q_in[l][DIV_LAT-2:0], 1'b1};
        end else begin
          rem_q[k][l] <= rem_in[l];
          q_q[k][l]   <= {q_in[l][DIV_LAT-2:0], 1'b0};
        end
      end
    end
  end

  assign quo = q_q[DIV_LAT-1];

endmodule

// ----- rtl/dqg_norm.sv -----
// dqg_norm: vector normalizer to Q2.14, squares, sum, square root and
// divide in a fixed-latency pipeline; depends on dqg_pkg, dqg_sqrt, dqg_div
`timescale 1ns / 1ps
module dqg_norm import dqg_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   in_valid,
  input  vec3c_t c_in,
  output logic   out_valid,
  output unit3_t r_out
);

  logic [2:0][47:0] sq;
  vec3c_t           c1;
  logic             v1;
  logic [49:0]      len;
  vec3c_t           c2;
  logic             v2;

  vec3c_t dly_c [SQRT_LAT];
  logic   dly_z [SQRT_LAT];
  logic   dly_v [SQRT_LAT];

  logic [2:0] sgn_d [DIV_LAT];
  logic       z_d   [DIV_LAT];
  logic       v_d   [DIV_LAT];

  logic [31:0]              root;
  logic [2:0][47:0]         num;
  logic [2:0][DIV_LAT-1:0]  quo;
  logic [2:0]               sgn;

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      sq[k] <= 48'($signed(c_in[k]) * $signed(c_in[k]));
    end
    c1  <= c_in;
    len <= {2'b0, sq[0]} + {2'b0, sq[1]} + {2'b0, sq[2]};
    c2  <= c1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= in_valid;
      v2 <= v1;
    end
  end

  dqg_sqrt u_sqrt (
    .clk      (clk),
    .radicand ({len, 14'd0}),
    .root     (root)
  );

  always_ff @(posedge clk) begin
    dly_c[0] <= c2;
    dly_z[0] <= (len == '0);
    for (int i = 1; i < SQRT_LAT; i++) begin
      dly_c[i] <= dly_c[i-1];
      dly_z[i] <= dly_z[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SQRT_LAT; i++) dly_v[i] <= 1'b0;
    end else begin
      dly_v[0] <= v2;
      for (int i = 1; i < SQRT_LAT; i++) dly_v[i] <= dly_v[i-1];
    end
  end

  always_comb begin
    logic [23:0] mag;
    for (int k = 0; k < 3; k++) begin
      sgn[k] = dly_c[SQRT_LAT-1][k][23];
      mag    = sgn[k] ? 24'(-$signed(dly_c[SQRT_LAT-1][k])) : dly_c[SQRT_LAT-1][k];
      num[k] = {3'b0, mag, 21'd0};
    end
  end

  dqg_div u_div (
    .clk (clk),
    .num (num),
    .den (root),
    .quo (quo)
  );

  always_ff @(posedge clk) begin
    sgn_d[0] <= sgn;
    z_d[0]   <= dly_z[SQRT_LAT-1];
    for (int i = 1; i < DIV_LAT; i++) begin
      sgn_d[i] <= sgn_d[i-1];
      z_d[i]   <= z_d[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DIV_LAT; i++) v_d[i] <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v_d[0] <= dly_v[SQRT_LAT-1];
      for (int i = 1; i < DIV_LAT; i++) v_d[i] <= v_d[i-1];
      out_valid <= v_d[DIV_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      if (z_d[DIV_LAT-1]) begin
        r_out[k] <= '0;
      end else if (sgn_d[DIV_LAT-1][k]) begin
        r_out[k] <= 16'(-$signed({1'b0, quo[k]}));
      end else begin
        r_out[k] <= {1'b0, quo[k]};
      end
    end
  end

endmodule

// ----- rtl/dqg_corner.sv -----
// dqg_corner: issues the four corners of a kept item, one per cycle,
// through a three-stage offset, scale and saturate pipeline; depends on dqg_pkg
`timescale 1ns / 1ps
module dqg_corner import dqg_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  pos3_t       pos,
  input  unit3_t      right,
  input  unit3_t      up,
  input  logic [30:0] half_size,
  output logic        result_valid,
  output result_t     result
);

  pos3_t       bank_pos;
  unit3_t      bank_right;
  unit3_t      bank_up;
  logic        active;
  logic [1:0]  cnt;

  logic              a_v;
  logic [1:0]        a_idx;
  pos3_t             a_pos;
  logic [2:0][16:0]  a_dir;

  logic              b_v;
  logic [1:0]        b_idx;
  pos3_t             b_pos;
  logic [2:0][48:0]  b_prod;

  logic [2:0][31:0]  c_vert;

  always_ff @(posedge clk) begin
    if (in_valid) begin
      bank_pos   <= pos;
      bank_right <= right;
      bank_up    <= up;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      cnt    <= '0;
    end else if (in_valid) begin
      active <= 1'b1;
      cnt    <= '0;
    end else if (active) begin
      cnt <= cnt + 2'd1;
      if (cnt == LAST_CORNER_IDX) begin
        active <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    logic signed [16:0] rt;
    logic signed [16:0] ut;
    for (int k = 0; k < 3; k++) begin
      rt = corner_cx_neg(cnt) ? 17'(-$signed(bank_right[k])) : 17'($signed(bank_right[k]));
      ut = corner_cy_neg(cnt) ? 17'(-$signed(bank_up[k])) : 17'($signed(bank_up[k]));
      a_dir[k] <= rt + ut;
    end
    a_idx <= cnt;
    a_pos <= bank_pos;
    b_idx <= a_idx;
    b_pos <= a_pos;
    for (int k = 0; k < 3; k++) begin
      b_prod[k] <= 49'($signed({1'b0, half_size}) * $signed(a_dir[k]));
    end
  end

  always_comb begin
    logic signed [48:0] adj;
    logic signed [34:0] off;
    logic signed [35:0] sum;
    for (int k = 0; k < 3; k++) begin
      adj = $signed(b_prod[k]) + (b_prod[k][48] ? 49'sd16383 : 49'sd0);
      off = 35'(adj >>> 14);
      sum = 36'($signed(b_pos[k])) + 36'(off);
      if (sum > 36'sd2147483647) begin
        c_vert[k] = 32'h7fff_ffff;
      end else if (sum < -36'sd2147483648) begin
        c_vert[k] = 32'h8000_0000;
      end else begin
        c_vert[k] = sum[31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    result.vert_x      <= c_vert[0];
    result.vert_y      <= c_vert[1];
    result.vert_z      <= c_vert[2];
    result.tex_u       <= corner_u(b_idx);
    result.tex_v       <= corner_v(b_idx);
    result.last_corner <= (b_idx == LAST_CORNER_IDX);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_v          <= 1'b0;
      b_v          <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      a_v          <= active;
      b_v          <= a_v;
      result_valid <= b_v;
    end
  end

endmodule

// ----- rtl/decal_quad_generator_core.sv -----
// decal_quad_generator_core: top level, config registers, distance cull,
// basis build and corner issue; depends on dqg_pkg, dqg_norm, dqg_corner
//
// usage
//   an item (hit point, normal, viewer) is taken at a clock edge with start
//   high and busy low. busy goes high after each taken item and stays high
//   while the throttle counter thr runs down, so items enter no faster than
//   the single result port gives out the four corners of a kept item.
//   a kept item gives four results on consecutive cycles, each marked by
//   result_valid for one cycle; last_corner flags the fourth. a culled item
//   gives nothing.
//   the depth from the taking edge to the first corner is set mainly by the
//   two normalizers, each a 32-stage square root followed by a 15-stage
//   divider.
//   registers are written through cfg_valid/cfg_ready/cfg_index/cfg_data,
//   cfg_ready is always high; write them only while no item is in flight.
//   rst (synchronous) empties the pipeline and loads the register defaults.
//   the receiver cannot stall, so results are never held back.
`timescale 1ns / 1ps
module decal_quad_generator_core import dqg_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  item_t       item,
  output logic        result_valid,
  output result_t     result,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  logic [1:0]  effect_level;
  logic [39:0] cull_far_sq;
  logic [39:0] cull_near_sq;
  logic [30:0] half_size;
  logic [1:0]  thr;
  logic        accept;

  // stage 1
  logic             v1;
  logic [2:0][24:0] mag1;
  vec3c_t           c1;
  pos3_t            pos1;
  logic [2:0][15:0] nrm1;
  // stage 2, 3
  logic             v2;
  logic [2:0][49:0] sq2;
  logic             keep3;

  logic  keep_dly [NORM_LAT-2];
  pos3_t pos_dly  [NORM_LAT];
  logic [2:0][15:0] nrm_dly [NORM_LAT];

  logic   rv;
  unit3_t right;

  // up cross product stages
  logic             u1_v;
  logic [5:0][31:0] u1_p;
  unit3_t           u1_r;
  pos3_t            u1_pos;
  logic             u2_v;
  vec3c_t           u2_c;
  unit3_t           u2_r;
  pos3_t            u2_pos;

  unit3_t r_dly   [NORM_LAT];
  pos3_t  pos2_dly [NORM_LAT];

  logic   uv;
  unit3_t up;

  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;
  assign busy      = (thr != 2'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      effect_level <= 2'd0;
      cull_far_sq  <= 40'd640000;
      cull_near_sq <= 40'd250000;
      half_size    <= 31'd327680;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_EFFECT_LEVEL: effect_level <= cfg_data[1:0];
        REG_CULL_FAR_SQ:  cull_far_sq  <= cfg_data[39:0];
        REG_CULL_NEAR_SQ: cull_near_sq <= cfg_data[39:0];
        REG_HALF_SIZE:    half_size    <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= '0;
    end else if (accept) begin
      thr <= 2'd3;
    end else if (thr != 2'd0) begin
      thr <= thr - 2'd1;
    end
  end

  // stage 1: distance magnitudes and helper cross product
  always_ff @(posedge clk) begin
    logic signed [32:0] d;
    logic [32:0]        m;
    logic signed [23:0] nx;
    logic signed [23:0] ny;
    logic signed [23:0] nz;
    pos3_t              p;
    pos3_t              w;
    p  = {item.hit_x, item.hit_y, item.hit_z};
    w  = {item.viewer_x, item.viewer_y, item.viewer_z};
    nx = 24'(item.norm_x);
    ny = 24'(item.norm_y);
    nz = 24'(item.norm_z);
    for (int k = 0; k < 3; k++) begin
      d = 33'($signed(w[2-k])) - 33'($signed(p[2-k]));
      m = d[32] ? 33'(-d) : 33'(d);
      mag1[k] <= m[32:8];
    end
    if (item.norm_z >= 16'(AXIS_LIMIT) || item.norm_z <= -16'(AXIS_LIMIT)) begin
      c1[0] <= nz;
      c1[1] <= '0;
      c1[2] <= -nx;
    end else begin
      c1[0] <= -ny;
      c1[1] <= nx;
      c1[2] <= '0;
    end
    pos1 <= {item.hit_z, item.hit_y, item.hit_x};
    nrm1 <= {item.norm_z, item.norm_y, item.norm_x};
  end

  // stage 2: squares; stage 3: sum and cull compare
  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      sq2[k] <= 50'(mag1[k] * mag1[k]);
    end
  end

  always_ff @(posedge clk) begin
    logic [55:0] dist_sq;
    logic        cull;
    dist_sq = 56'(sq2[0]) + 56'(sq2[1]) + 56'(sq2[2]);
    cull = ((effect_level != 2'd0) && (dist_sq > {cull_far_sq, 16'd0})) ||
           ((effect_level == 2'd2) && (dist_sq > {cull_near_sq, 16'd0}));
    if (rst) begin
      v1    <= 1'b0;
      v2    <= 1'b0;
      keep3 <= 1'b0;
    end else begin
      v1    <= accept;
      v2    <= v1;
      keep3 <= v2 && !cull;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NORM_LAT - 2; i++) keep_dly[i] <= 1'b0;
    end else begin
      keep_dly[0] <= keep3;
      for (int i = 1; i < NORM_LAT - 2; i++) keep_dly[i] <= keep_dly[i-1];
    end
  end

  always_ff @(posedge clk) begin
    pos_dly[0] <= pos1;
    nrm_dly[0] <= nrm1;
    for (int i = 1; i < NORM_LAT; i++) begin
      pos_dly[i] <= pos_dly[i-1];
      nrm_dly[i] <= nrm_dly[i-1];
    end
  end

  dqg_norm u_norm_right (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v1),
    .c_in      (c1),
    .out_valid (rv),
    .r_out     (right)
  );

  // up = right x n, scaled down by 1024 toward zero
  always_ff @(posedge clk) begin
    logic [2:0][15:0] n;
    logic signed [32:0] dd;
    logic signed [32:0] adj;
    n = nrm_dly[NORM_LAT-1];
    u1_p[0] <= 32'($signed(right[1]) * $signed(n[2]));
    u1_p[1] <= 32'($signed(right[2]) * $signed(n[1]));
    u1_p[2] <= 32'($signed(right[2]) * $signed(n[0]));
    u1_p[3] <= 32'($signed(right[0]) * $signed(n[2]));
    u1_p[4] <= 32'($signed(right[0]) * $signed(n[1]));
    u1_p[5] <= 32'($signed(right[1]) * $signed(n[0]));
    u1_r    <= right;
    u1_pos  <= pos_dly[NORM_LAT-1];
    for (int k = 0; k < 3; k++) begin
      dd  = 33'($signed(u1_p[2*k])) - 33'($signed(u1_p[2*k+1]));
      adj = dd + (dd[32] ? 33'sd1023 : 33'sd0);
      u2_c[k] <= 24'(adj >>> 10);
    end
    u2_r   <= u1_r;
    u2_pos <= u1_pos;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      u1_v <= 1'b0;
      u2_v <= 1'b0;
    end else begin
      u1_v <= rv && keep_dly[NORM_LAT-3];
      u2_v <= u1_v;
    end
  end

  always_ff @(posedge clk) begin
    r_dly[0]    <= u2_r;
    pos2_dly[0] <= u2_pos;
    for (int i = 1; i < NORM_LAT; i++) begin
      r_dly[i]    <= r_dly[i-1];
      pos2_dly[i] <= pos2_dly[i-1];
    end
  end

  dqg_norm u_norm_up (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (u2_v),
    .c_in      (u2_c),
    .out_valid (uv),
    .r_out     (up)
  );

  dqg_corner u_corner (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (uv),
    .pos          (pos2_dly[NORM_LAT-1]),
    .right        (r_dly[NORM_LAT-1]),
    .up           (up),
    .half_size    (half_size),
    .result_valid (result_valid),
    .result       (result)
  );

  a_throttle: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy ##1 busy ##1 busy)
    else $error("item taken inside the four-cycle window");

  a_burst: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.last_corner |=> result_valid)
    else $error("corner burst broken");

  a_last_after_three: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.last_corner |->
      $past(result_valid, 1) && $past(result_valid, 2) && $past(result_valid, 3))
    else $error("last corner without three before it");

  a_first_corner: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.tex_u && !result.tex_v |-> !result.last_corner)
    else $error("first corner flagged last");

endmodule

// ----- tb/tb_decal_quad_generator_core.sv -----
// tb_decal_quad_generator_core: self-checking bench for the decal quad generator,
// directed and random hits through several register settings, corner scoreboard
// depends on dqg_pkg and decal_quad_generator_core
`timescale 1ns / 1ps
module tb_decal_quad_generator_core;
  import dqg_pkg::*;

  typedef longint vec3_t [3];

  class corner_scoreboard;
    logic [1:0]  level;
    logic [39:0] far_sq;
    logic [39:0] near_sq;
    logic [30:0] half;
    result_t     corner_q[$];
    int          errors;

    function new();
      level   = 2'd0;
      far_sq  = 40'd640000;
      near_sq = 40'd250000;
      half    = 31'd327680;
      errors  = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [63:0] data);
      case (idx)
        REG_EFFECT_LEVEL: level   = data[1:0];
        REG_CULL_FAR_SQ:  far_sq  = data[39:0];
        REG_CULL_NEAR_SQ: near_sq = data[39:0];
        REG_HALF_SIZE:    half    = data[30:0];
        default: ;
      endcase
    endfunction

    function longint unsigned root(longint unsigned x);
      longint unsigned res;
      longint unsigned b;
      res = 0;
      b = 64'd1 << 62;
      while (b > x) b = b >> 2;
      while (b != 0) begin
        if (x >= res + b) begin
          x = x - (res + b);
          res = (res >> 1) + b;
        end else begin
          res = res >> 1;
        end
        b = b >> 2;
      end
      return res;
    endfunction

    function vec3_t unit_of(vec3_t c);
      vec3_t r;
      longint unsigned len;
      longint s;
      len = 0;
      for (int k = 0; k < 3; k++) len += longint'(c[k] * c[k]);
      if (len == 0) begin
        r = '{0, 0, 0};
      end else begin
        s = longint'(root(len << 14));
        for (int k = 0; k < 3; k++) r[k] = (c[k] * 64'sd2097152) / s;
      end
      return r;
    endfunction

    function longint unsigned dist_part(longint d);
      longint unsigned mag;
      mag = (d < 0) ? longint'(-d) : longint'(d);
      mag = mag >> 8;
      return mag * mag;
    endfunction

    function void note_item(item_t it);
      vec3_t pos, nrm, view, c, rv, uv;
      longint unsigned dist_sum;
      longint dirc, off, v;
      result_t r;
      int cx [4] = '{-1, -1, 1, 1};
      int cy [4] = '{-1, 1, 1, -1};
      pos  = '{longint'(it.hit_x), longint'(it.hit_y), longint'(it.hit_z)};
      nrm  = '{longint'(it.norm_x), longint'(it.norm_y), longint'(it.norm_z)};
      view = '{longint'(it.viewer_x), longint'(it.viewer_y), longint'(it.viewer_z)};
      dist_sum = 0;
      for (int k = 0; k < 3; k++) dist_sum += dist_part(view[k] - pos[k]);
      if (level >= 1 && dist_sum > (longint'(far_sq) << 16)) return;
      if (level == 2 && dist_sum > (longint'(near_sq) << 16)) return;
      if (nrm[2] >= AXIS_LIMIT || nrm[2] <= -AXIS_LIMIT) c = '{nrm[2], 0, -nrm[0]};
      else c = '{-nrm[1], nrm[0], 0};
      rv = unit_of(c);
      c[0] = (rv[1] * nrm[2] - rv[2] * nrm[1]) / 1024;
      c[1] = (rv[2] * nrm[0] - rv[0] * nrm[2]) / 1024;
      c[2] = (rv[0] * nrm[1] - rv[1] * nrm[0]) / 1024;
      uv = unit_of(c);
      for (int i = 0; i < 4; i++) begin
        for (int k = 0; k < 3; k++) begin
          dirc = cx[i] * rv[k] + cy[i] * uv[k];
          off = (longint'(half) * dirc) / 16384;
          v = pos[k] + off;
          if (v > 64'sd2147483647) v = 64'sd2147483647;
          if (v < -64'sd2147483648) v = -64'sd2147483648;
          if (k == 0) r.vert_x = v[31:0];
          else if (k == 1) r.vert_y = v[31:0];
          else r.vert_z = v[31:0];
        end
        r.tex_u = (i < 2);
        r.tex_v = (i == 1 || i == 2);
        r.last_corner = (i == 3);
        corner_q = {corner_q, r};
      end
    endfunction

    function void check_corner(result_t got);
      result_t exp_c;
      if (corner_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected corner %h", got);
        return;
      end
      exp_c = corner_q.pop_front();
      if (got.vert_x !== exp_c.vert_x || got.vert_y !== exp_c.vert_y ||
          got.vert_z !== exp_c.vert_z || got.tex_u !== exp_c.tex_u ||
          got.tex_v !== exp_c.tex_v || got.last_corner !== exp_c.last_corner) begin
        errors++;
        if (errors <= 10) begin
          $display("corner mismatch: exp x=%h y=%h z=%h u=%b v=%b l=%b",
                   exp_c.vert_x, exp_c.vert_y, exp_c.vert_z, exp_c.tex_u, exp_c.tex_v,
                   exp_c.last_corner);
          $display("                 got x=%h y=%h z=%h u=%b v=%b l=%b",
                   got.vert_x, got.vert_y, got.vert_z, got.tex_u, got.tex_v,
                   got.last_corner);
        end
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  item_t       item_in = '0;
  logic        result_valid;
  result_t     result;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = REG_EFFECT_LEVEL;
  logic [63:0] cfg_data = '0;

  corner_scoreboard sb = new();
  int idle_cycles = 0;
  bit allow_idle = 1'b1;

  always #2 clk = ~clk;

  decal_quad_generator_core u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .item(item_in),
    .result_valid(result_valid), .result(result), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always @(posedge clk) begin
    if (!rst && result_valid) sb.check_corner(result);
  end

  always @(posedge clk) begin
    if (rst || result_valid || (start && !busy) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= 3000) begin
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_item(item_t it);
    item_in <= it;
    if (!start) start <= 1'b1;
    do @(posedge clk); while (busy);
    sb.note_item(it);
    if (allow_idle && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
  endtask

  // hold off until every corner is out, then let culled items drain
  task automatic drain();
    if (start) start <= 1'b0;
    while (sb.corner_q.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [63:0] data);
    cfg_index <= idx;
    cfg_data <= data;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [15:0] rand_norm();
    return 16'($signed($urandom_range(0, 32768)) - 16384);
  endfunction

  function automatic item_t rand_item(int mode);
    item_t it;
    int span;
    it.hit_x = $urandom; it.hit_y = $urandom; it.hit_z = $urandom;
    if (mode == 0) begin
      span = $urandom_range(0, 1100);
      it.viewer_x = it.hit_x + $signed($urandom_range(0, 2 * span)) * 65536 - span * 65536;
      it.viewer_y = it.hit_y + $signed($urandom_range(0, 2 * span)) * 65536 - span * 65536;
      it.viewer_z = it.hit_z + $signed($urandom_range(0, 65535)) - 32768;
      it.norm_x = rand_norm(); it.norm_y = rand_norm();
      it.norm_z = ($urandom_range(0, 3) == 0) ? 16'($signed($urandom_range(16210, 16384))) :
                  rand_norm();
      if ($urandom_range(0, 1)) it.norm_z = -it.norm_z;
    end else begin
      it.viewer_x = $urandom; it.viewer_y = $urandom; it.viewer_z = $urandom;
      it.norm_x = $urandom; it.norm_y = $urandom; it.norm_z = $urandom;
    end
    return it;
  endfunction

  function automatic item_t mk(logic [15:0] nx, logic [15:0] ny, logic [15:0] nz,
                               logic [31:0] h, logic [31:0] vw);
    item_t it;
    it.hit_x = h; it.hit_y = h; it.hit_z = h;
    it.norm_x = nx; it.norm_y = ny; it.norm_z = nz;
    it.viewer_x = vw; it.viewer_y = vw; it.viewer_z = vw;
    return it;
  endfunction

  task automatic random_phase(int n);
    for (int i = 0; i < n; i++) send_item(rand_item(($urandom_range(0, 4) == 0) ? 1 : 0));
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: axes, helper switch boundary, zero normal, extremes
    send_item(mk(16'sd0, 16'sd0, 16'sd16384, 32'h0001_0000, 32'h0002_0000));
    send_item(mk(16'sd0, 16'sd0, -16'sd16384, 32'h0, 32'h0));
    send_item(mk(16'sd100, 16'sd0, 16'sd16221, 32'h0, 32'h0));
    send_item(mk(16'sd100, 16'sd0, 16'sd16220, 32'h0, 32'h0));
    send_item(mk(16'sd100, 16'sd0, -16'sd16221, 32'h0, 32'h0));
    send_item(mk(16'sd100, 16'sd0, -16'sd16220, 32'h0, 32'h0));
    send_item(mk(16'sd16384, 16'sd0, 16'sd0, 32'h0, 32'h0));
    send_item(mk(16'sd0, 16'sd16384, 16'sd0, 32'h0, 32'h0));
    send_item(mk(16'sd0, 16'sd0, 16'sd0, 32'h1234_5678, 32'h0));
    send_item(mk(16'h8000, 16'h8000, 16'h8000, 32'h7fff_ffff, 32'h8000_0000));
    send_item(mk(16'h7fff, 16'h7fff, 16'h7fff, 32'h8000_0000, 32'h7fff_ffff));
    send_item(mk(16'h8000, 16'h7fff, 16'h0000, 32'h7fff_fff0, 32'h7fff_fff0));
    drain();
    write_reg(REG_HALF_SIZE, 64'hffff_ffff_ffff_ffff);
    send_item(mk(16'sd11585, 16'sd0, 16'sd11585, 32'h7fff_0000, 32'h7fff_0000));
    send_item(mk(16'sd0, -16'sd11585, 16'sd11585, 32'h8000_1000, 32'h8000_1000));
    drain();
    write_reg(REG_HALF_SIZE, 64'h0);
    send_item(mk(16'sd0, 16'sd16384, 16'sd0, 32'h5555_5555, 32'h5555_5555));
    drain();
    write_reg(REG_HALF_SIZE, 64'd327680);
    write_reg(REG_EFFECT_LEVEL, 64'd1);
    send_item(mk(16'sd0, 16'sd0, 16'sd16384, 32'h0, 32'd800 << 16));
    send_item(mk(16'sd0, 16'sd0, 16'sd16384, 32'h0, 32'd462 << 16));
    send_item(mk(16'sd0, 16'sd0, 16'sd16384, 32'h0, 32'd463 << 16));
    drain();
    write_reg(REG_EFFECT_LEVEL, 64'd2);
    send_item(mk(16'sd0, 16'sd0, 16'sd16384, 32'h0, 32'd288 << 16));
    send_item(mk(16'sd0, 16'sd0, 16'sd16384, 32'h0, 32'd289 << 16));
    drain();
    write_reg(REG_EFFECT_LEVEL, 64'd3);
    send_item(mk(16'sd0, 16'sd0, 16'sd16384, 32'h0, 32'd289 << 16));
    send_item(mk(16'sd0, 16'sd0, 16'sd16384, 32'h0, 32'd463 << 16));
    drain();

    // random: several register settings, extremes among them
    write_reg(REG_EFFECT_LEVEL, 64'd0);
    random_phase(60);
    drain();
    write_reg(REG_EFFECT_LEVEL, {$urandom, $urandom} | 64'd1 & ~64'd2);
    write_reg(REG_CULL_FAR_SQ, {$urandom, 12'h0, 20'($urandom_range(100000, 900000))});
    write_reg(REG_HALF_SIZE, {$urandom, 1'b0, 31'($urandom_range(0, 2000000))});
    random_phase(60);
    drain();
    write_reg(REG_EFFECT_LEVEL, 64'd2);
    write_reg(REG_CULL_NEAR_SQ, {$urandom, 12'h0, 20'($urandom_range(50000, 700000))});
    write_reg(REG_HALF_SIZE, 64'h7fff_ffff);
    random_phase(60);
    drain();
    write_reg(REG_EFFECT_LEVEL, 64'd3);
    write_reg(REG_CULL_FAR_SQ, 64'h0);
    write_reg(REG_CULL_NEAR_SQ, 64'hff_ffff_ffff);
    random_phase(50);
    drain();
    write_reg(REG_EFFECT_LEVEL, 64'd2);
    write_reg(REG_CULL_FAR_SQ, 64'hff_ffff_ffff);
    write_reg(REG_CULL_NEAR_SQ, 64'h0);
    write_reg(REG_HALF_SIZE, {$urandom, $urandom});
    random_phase(50);
    drain();
    write_reg(REG_EFFECT_LEVEL, 64'd1);
    write_reg(REG_CULL_FAR_SQ, {$urandom, $urandom});
    write_reg(REG_HALF_SIZE, 64'd327680);
    random_phase(60);
    drain();
    write_reg(REG_EFFECT_LEVEL, 64'd0);
    allow_idle = 1'b0;
    random_phase(50);

    start <= 1'b0;
    while (sb.corner_q.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);
    if (sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
